// ----- rtl/ilp_pkg.sv -----
// shared types and constants for the 3x3 yuv smoothing filter
// no dependencies; imported by every rtl module except ilp_ram
package ilp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = COL_W + 1;
  localparam int HGT_W  = ROW_W + 1;
  localparam int PIX_W  = 24;
  localparam int SMP_W  = 8;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  // queue between front and back, power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // kernel arithmetic: sum of nine samples plus rounding fits 12 bits
  localparam int SUM_W       = 12;
  localparam int ROUND_ADD   = 4;
  localparam int CROSS_SHIFT = 3;
  localparam int RECIP_W     = 12;
  localparam int RECIP_9     = 3641;
  localparam int RECIP_SHIFT = 15;

  // register map
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t             px;
    pix_t             up1;
    pix_t             up2;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             emit;
    logic             last_col;
    logic             last_row;
    logic             border;
  } entry_t;

endpackage

// ----- rtl/ilp_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// read-first when both ports hit the same address; no dependencies
module ilp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ilp_fifo.sv -----
// short queue of classified words between the front and the back
// depends on ilp_pkg
module ilp_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  ilp_pkg::entry_t           push_data,
  input  logic                      pop,
  output ilp_pkg::entry_t           head,
  output logic                      empty,
  output logic [ilp_pkg::QCNT_W-1:0] count
);
  import ilp_pkg::*;

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/ilp_front.sv -----
// front: accepts pixels, tracks raster position, reads and updates the
// two line stores and classifies each word; depends on ilp_pkg, ilp_ram
module ilp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ilp_pkg::SMP_W-1:0]  luma_in,
  input  logic [ilp_pkg::SMP_W-1:0]  cb_in,
  input  logic [ilp_pkg::SMP_W-1:0]  cr_in,
  input  logic [ilp_pkg::WID_W-1:0]  frame_width,
  input  logic [ilp_pkg::HGT_W-1:0]  frame_height,
  input  logic [ilp_pkg::QCNT_W-1:0] fifo_count,
  output logic                       push,
  output ilp_pkg::entry_t            push_data
);
  import ilp_pkg::*;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic             wrap;
  logic [COL_W-1:0] c_eff;
  logic [HGT_W-1:0] r_tmp;
  logic [ROW_W-1:0] r_eff;
  logic [WID_W-1:0] c_inc;
  logic [HGT_W-1:0] r_inc;
  logic             col_end;
  logic             row_end;
  logic             accept;
  pix_t             px;
  pix_t             up1;
  pix_t             up2;

  logic             f1_valid;
  pix_t             f1_px;
  logic [COL_W-1:0] f1_col;
  logic [ROW_W-1:0] f1_row;
  logic             f1_emit;
  logic             f1_last_col;
  logic             f1_last_row;
  logic             f1_border;

  // room is reserved for the word already in flight through the ram read
  assign in_ready = ({1'b0, fifo_count} + {{QCNT_W{1'b0}}, f1_valid})
                    < (QCNT_W + 1)'(QDEPTH);
  assign accept   = in_valid && in_ready;
  assign px       = {cr_in, cb_in, luma_in};

  always_comb begin
    if (frame_width < WID_W'(3)) begin
      w_eff = WID_W'(3);
    end else if (frame_width > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < HGT_W'(3)) begin
      h_eff = HGT_W'(3);
    end else if (frame_height > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // a position left beyond a shrunken frame wraps before use
  always_comb begin
    wrap    = {1'b0, col_count} >= w_eff;
    c_eff   = wrap ? '0 : col_count;
    r_tmp   = {1'b0, row_count} + {{ROW_W{1'b0}}, wrap};
    r_eff   = (r_tmp >= h_eff) ? '0 : r_tmp[ROW_W-1:0];
    c_inc   = {1'b0, c_eff} + 1'b1;
    r_inc   = {1'b0, r_eff} + 1'b1;
    col_end = c_inc >= w_eff;
    row_end = r_inc >= h_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : r_inc[ROW_W-1:0];
      end else begin
        col_count <= c_inc[COL_W-1:0];
        row_count <= r_eff;
      end
    end
  end

  // store a holds the previous line, store b the one before it
  ilp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (accept),
    .waddr (c_eff),
    .wdata (px),
    .re    (accept),
    .raddr (c_eff),
    .rdata (up1)
  );

  ilp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (f1_valid),
    .waddr (f1_col),
    .wdata (up1),
    .re    (accept),
    .raddr (c_eff),
    .rdata (up2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_px       <= px;
      f1_col      <= c_eff;
      f1_row      <= r_eff;
      f1_emit     <= (r_eff != '0) && (c_eff != '0);
      f1_last_col <= col_end;
      f1_last_row <= row_end;
      f1_border   <= (r_eff == ROW_W'(1)) || (c_eff == COL_W'(1));
    end
  end

  assign push = f1_valid;

  always_comb begin
    push_data.px       = f1_px;
    push_data.up1      = up1;
    push_data.up2      = up2;
    push_data.col      = f1_col;
    push_data.row      = f1_row;
    push_data.emit     = f1_emit;
    push_data.last_col = f1_last_col;
    push_data.last_row = f1_last_row;
    push_data.border   = f1_border;
  end

endmodule

// ----- rtl/ilp_back.sv -----
// back: shifts the 3x3 window, forms the kernel sums and sends up to four
// results per word through an output register; depends on ilp_pkg
module ilp_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      kernel_mode,
  input  ilp_pkg::entry_t           head,
  input  logic                      fifo_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ilp_pkg::ROW_W-1:0] out_row,
  output logic [ilp_pkg::COL_W-1:0] out_col,
  output logic [ilp_pkg::SMP_W-1:0] luma_out,
  output logic [ilp_pkg::SMP_W-1:0] cb_out,
  output logic [ilp_pkg::SMP_W-1:0] cr_out,
  output logic                      run_last,
  output logic                      frame_done
);
  import ilp_pkg::*;

  localparam logic [1:0] RES_CENTRE = 2'd0;
  localparam logic [1:0] RES_RIGHT  = 2'd1;
  localparam logic [1:0] RES_BELOW  = 2'd2;
  localparam logic [1:0] RES_CORNER = 2'd3;
  localparam int         PROD_W     = SUM_W + RECIP_W;

  // win[row*3+col]: row 0 oldest line, col 2 newest column
  pix_t             win [9];
  logic [SUM_W-1:0] sum_next [3];
  logic [SUM_W-1:0] sum_q [3];
  pix_t             smooth;

  logic             cur_valid;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             cur_border;
  logic [3:0]       rem;
  logic [3:0]       rem_clr;
  logic [1:0]       sel;
  logic             emit_fire;
  logic             last_emit;

  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  pix_t             res_pix;

  always_comb begin
    if (rem[0]) begin
      sel = RES_CENTRE;
    end else if (rem[1]) begin
      sel = RES_RIGHT;
    end else if (rem[2]) begin
      sel = RES_BELOW;
    end else begin
      sel = RES_CORNER;
    end
  end

  assign rem_clr   = rem & (rem - 1'b1);
  assign last_emit = (rem_clr == '0);
  assign emit_fire = cur_valid && (!out_valid || out_ready);
  assign pop       = !fifo_empty && (!cur_valid || (emit_fire && last_emit));

  // sums over the window as it will be after this word shifts in
  always_comb begin
    logic [SUM_W-1:0] s9;
    logic [SUM_W-1:0] s5;
    for (int p = 0; p < 3; p++) begin
      s9 = SUM_W'(win[1][8*p +: 8]) + SUM_W'(win[2][8*p +: 8])
         + SUM_W'(win[4][8*p +: 8]) + SUM_W'(win[5][8*p +: 8])
         + SUM_W'(win[7][8*p +: 8]) + SUM_W'(win[8][8*p +: 8])
         + SUM_W'(head.up2[8*p +: 8]) + SUM_W'(head.up1[8*p +: 8])
         + SUM_W'(head.px[8*p +: 8]);
      s5 = SUM_W'(win[2][8*p +: 8]) + SUM_W'(win[8][8*p +: 8])
         + SUM_W'(win[4][8*p +: 8]) + SUM_W'(head.up1[8*p +: 8])
         + SUM_W'({win[5][8*p +: 8], 2'b00});
      sum_next[p] = (kernel_mode ? s9 : s5) + SUM_W'(ROUND_ADD);
    end
  end

  // divide by nine as multiply by scaled reciprocal, or by eight as a shift
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int p = 0; p < 3; p++) begin
      prod = PROD_W'(sum_q[p]) * PROD_W'(RECIP_9);
      if (kernel_mode) begin
        smooth[8*p +: 8] = prod[RECIP_SHIFT +: SMP_W];
      end else begin
        smooth[8*p +: 8] = sum_q[p][CROSS_SHIFT +: SMP_W];
      end
    end
  end

  always_comb begin
    unique case (sel)
      RES_CENTRE: begin
        res_row = cur_row - 1'b1;
        res_col = cur_col - 1'b1;
        res_pix = cur_border ? win[4] : smooth;
      end
      RES_RIGHT: begin
        res_row = cur_row - 1'b1;
        res_col = cur_col;
        res_pix = win[5];
      end
      RES_BELOW: begin
        res_row = cur_row;
        res_col = cur_col - 1'b1;
        res_pix = win[7];
      end
      default: begin
        res_row = cur_row;
        res_col = cur_col;
        res_pix = win[8];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]     <= win[i*3 + 1];
        win[i*3 + 1] <= win[i*3 + 2];
      end
      win[2] <= head.up2;
      win[5] <= head.up1;
      win[8] <= head.px;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int p = 0; p < 3; p++) begin
        sum_q[p] <= sum_next[p];
      end
      cur_row    <= head.row;
      cur_col    <= head.col;
      cur_border <= head.border;
      rem        <= {head.last_col & head.last_row, head.last_row, head.last_col, 1'b1};
    end else if (emit_fire) begin
      rem <= rem_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= head.emit;
    end else if (emit_fire && last_emit) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row    <= res_row;
      out_col    <= res_col;
      luma_out   <= res_pix[7:0];
      cb_out     <= res_pix[15:8];
      cr_out     <= res_pix[23:16];
      run_last   <= last_emit;
      frame_done <= (sel == RES_CORNER);
    end
  end

endmodule

// ----- rtl/image_lowpass_3x3.sv -----
// 3x3 smoothing filter, 4:4:4 yuv, one pixel word per clock unless stalled
//
// input channel: in_valid/in_ready with luma_in, cb_in, cr_in in raster
// order. output channel: out_valid/out_ready with the filtered pixel, its
// out_row/out_col, run_last on the last result of an input word and
// frame_done on the bottom right pixel. the first line and first column
// produce nothing; each later word produces one result, two at the right
// edge, two on the last line and four at the last pixel of the frame.
// the frame border is copied, the interior uses the cross kernel
// (kernel_mode 0) or the 3x3 mean (kernel_mode 1). a word passes the ram
// read, queue, window and output registers. throughput: one word and one
// result per cycle while out_ready is high; a word with several results
// holds the output side until all are sent, bounded by the one output
// register. a 4-entry queue lets input keep flowing while the receiver
// stalls; when it fills, in_ready drops. reset clears position, window
// and config (mode 0, 640x480); the line stores need no clearing pass.
// registers over apb at 0x0 mode, 0x4 width, 0x8 height; write only
// while idle. depends on ilp_pkg, ilp_front, ilp_fifo, ilp_back
module image_lowpass_3x3 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ilp_pkg::SMP_W-1:0]    luma_in,
  input  logic [ilp_pkg::SMP_W-1:0]    cb_in,
  input  logic [ilp_pkg::SMP_W-1:0]    cr_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ilp_pkg::ROW_W-1:0]    out_row,
  output logic [ilp_pkg::COL_W-1:0]    out_col,
  output logic [ilp_pkg::SMP_W-1:0]    luma_out,
  output logic [ilp_pkg::SMP_W-1:0]    cb_out,
  output logic [ilp_pkg::SMP_W-1:0]    cr_out,
  output logic                         run_last,
  output logic                         frame_done,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ilp_pkg::PADDR_W-1:0]  paddr,
  input  logic [ilp_pkg::PDATA_W-1:0]  pwdata,
  output logic [ilp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import ilp_pkg::*;

  logic                  kernel_mode;
  logic [WID_W-1:0]      frame_width;
  logic [HGT_W-1:0]      frame_height;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  logic                  push;
  entry_t                push_data;
  entry_t                head;
  logic                  pop;
  logic                  fifo_empty;
  logic [QCNT_W-1:0]     fifo_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode  <= 1'b0;
      frame_width  <= WID_W'(WIDTH_RST);
      frame_height <= HGT_W'(HEIGHT_RST);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:   kernel_mode  <= pwdata[0];
        REG_WIDTH:  frame_width  <= pwdata[WID_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = PDATA_W'(kernel_mode);
      REG_WIDTH:  prdata = PDATA_W'(frame_width);
      REG_HEIGHT: prdata = PDATA_W'(frame_height);
      default:    prdata = '0;
    endcase
  end

  ilp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .luma_in      (luma_in),
    .cb_in        (cb_in),
    .cr_in        (cr_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .fifo_count   (fifo_count),
    .push         (push),
    .push_data    (push_data)
  );

  ilp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty),
    .count     (fifo_count)
  );

  ilp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .kernel_mode (kernel_mode),
    .head        (head),
    .fifo_empty  (fifo_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .luma_out    (luma_out),
    .cb_out      (cb_out),
    .cr_out      (cr_out),
    .run_last    (run_last),
    .frame_done  (frame_done)
  );

endmodule

// ----- rtl/ilp_check.sv -----
// port-level checks for the smoothing filter, bound to its top level
// depends on ilp_pkg and image_lowpass_3x3
module ilp_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ilp_pkg::ROW_W-1:0] out_row,
  input logic [ilp_pkg::COL_W-1:0] out_col,
  input logic [ilp_pkg::SMP_W-1:0] luma_out,
  input logic [ilp_pkg::SMP_W-1:0] cb_out,
  input logic [ilp_pkg::SMP_W-1:0] cr_out,
  input logic                      run_last,
  input logic                      frame_done
);
  import ilp_pkg::*;

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(luma_out) && $stable(cb_out) && $stable(cr_out)
      && $stable(run_last) && $stable(frame_done))
    else $error("stalled output word changed");

  // the frame corner is its word's last result, never in row or col 0
  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last && out_row != '0 && out_col != '0)
    else $error("frame_done on a bad result");

  // results of one word leave without gaps
  a_run_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside a run of results");

endmodule

bind image_lowpass_3x3 ilp_check u_check (.*);

// ----- tb/sv/image_lowpass_3x3_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for image_lowpass_3x3: streams whole yuv frames, predicts
// every output word in step with the input and checks it field by field.
// depends on ilp_pkg and the rtl of the block; reads no files.
module image_lowpass_3x3_tb;
  import ilp_pkg::*;

  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PIXELS = 120;
  localparam int STALL_LEN   = 300;

  typedef logic [SMP_W-1:0] smp_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    smp_t             y;
    smp_t             u;
    smp_t             v;
    logic             last;
    logic             done;
  } out_word_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  smp_t               luma_in   = '0;
  smp_t               cb_in     = '0;
  smp_t               cr_in     = '0;
  logic               out_ready = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;

  logic               in_ready;
  logic               out_valid;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  smp_t               luma_out;
  smp_t               cb_out;
  smp_t               cr_out;
  logic               run_last;
  logic               frame_done;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  image_lowpass_3x3 uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .luma_in    (luma_in),
    .cb_in      (cb_in),
    .cr_in      (cr_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .luma_out   (luma_out),
    .cb_out     (cb_out),
    .cr_out     (cr_out),
    .run_last   (run_last),
    .frame_done (frame_done),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  // filter state as seen from outside: line stores, window, position, registers
  pix_t             line_prev [MAX_WIDTH];
  pix_t             line_older[MAX_WIDTH];
  pix_t             win[9]     = '{default: '0};
  int               next_col   = 0;
  int               next_row   = 0;
  logic             cfg_mode   = 1'b0;
  logic [WID_W-1:0] cfg_width  = WID_W'(WIDTH_RST);
  logic [HGT_W-1:0] cfg_height = HGT_W'(HEIGHT_RST);
  out_word_t        words_due[$];

  int   pixels_sent = 0;
  int   words_seen  = 0;
  int   err_count   = 0;
  int   cycles      = 0;
  int   rx_wait     = 0;
  logic rx_hold     = 1'b0;
  logic rx_gaps     = 1'b1;
  bit   tx_gaps     = 1'b1;

  function automatic int eff_width();
    if (cfg_width < 3) return 3;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  function automatic int eff_height();
    if (cfg_height < 3) return 3;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(cfg_height);
  endfunction

  // win[row*3+col]: row 0 is the oldest line, col 2 the newest column
  function automatic pix_t smooth_window();
    pix_t res;
    int   s, k, p;
    res = '0;
    for (p = 0; p < 3; p++) begin
      s = 0;
      if (cfg_mode) begin
        for (k = 0; k < 9; k++) s += int'(win[k][8*p +: 8]);
        res[8*p +: 8] = smp_t'((s + 4) / 9);
      end else begin
        s = int'(win[1][8*p +: 8]) + int'(win[7][8*p +: 8]) + int'(win[3][8*p +: 8])
          + int'(win[5][8*p +: 8]) + 4 * int'(win[4][8*p +: 8]);
        res[8*p +: 8] = smp_t'((s + 4) >> 3);
      end
    end
    return res;
  endfunction

  function automatic out_word_t make_word(input int row, input int col, input pix_t px,
                                          input logic done);
    out_word_t wd;
    wd.row  = row[ROW_W-1:0];
    wd.col  = col[COL_W-1:0];
    wd.y    = px[7:0];
    wd.u    = px[15:8];
    wd.v    = px[23:16];
    wd.last = 1'b0;
    wd.done = done;
    return wd;
  endfunction

  function automatic bit at_frame_start();
    int c, r;
    c = next_col;
    r = next_row;
    if (c >= eff_width()) begin
      c = 0;
      r++;
    end
    if (r >= eff_height()) r = 0;
    return c == 0 && r == 0;
  endfunction

  // advance the filter by one accepted pixel and queue the words it releases
  task automatic filter_step(input smp_t y, input smp_t u, input smp_t v);
    int        w, h, c, r, k, n;
    pix_t      px, up1, up2;
    out_word_t words[4];
    logic      border;
    w = eff_width();
    h = eff_height();
    // geometry may have shrunk under the position
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    c   = next_col;
    r   = next_row;
    px  = {v, u, y};
    up1 = line_prev[c];
    up2 = line_older[c];
    for (k = 0; k < 9; k += 3) begin
      win[k]   = win[k+1];
      win[k+1] = win[k+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;
    line_older[c] = up1;
    line_prev[c]  = px;
    n = 0;
    if (r >= 1 && c >= 1) begin
      border = (r == 1) || (c == 1);
      words[n] = make_word(r - 1, c - 1, border ? win[4] : smooth_window(), 1'b0);
      n++;
      if (c == w - 1) begin
        words[n] = make_word(r - 1, w - 1, win[5], 1'b0);
        n++;
      end
      if (r == h - 1) begin
        words[n] = make_word(h - 1, c - 1, win[7], 1'b0);
        n++;
        if (c == w - 1) begin
          words[n] = make_word(h - 1, w - 1, win[8], 1'b1);
          n++;
        end
      end
      words[n-1].last = 1'b1;
      for (k = 0; k < n; k++) words_due.push_back(words[k]);
    end
    next_col = c + 1;
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end
  endtask

  // output side: checks each word and draws the next ready gap
  always @(posedge clk) begin
    out_word_t want;
    int        gap;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      gap = rx_wait;
      if (out_valid && out_ready) begin
        words_seen++;
        if (words_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected word %0d: row %0d col %0d yuv %0d %0d %0d last %b done %b",
                     words_seen, out_row, out_col, luma_out, cb_out, cr_out,
                     run_last, frame_done);
        end else begin
          want = words_due.pop_front();
          if (out_row !== want.row || out_col !== want.col || luma_out !== want.y ||
              cb_out !== want.u || cr_out !== want.v || run_last !== want.last ||
              frame_done !== want.done) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch on word %0d", words_seen);
              $display("  want row %0d col %0d yuv %0d %0d %0d last %b done %b",
                       want.row, want.col, want.y, want.u, want.v, want.last, want.done);
              $display("  got  row %0d col %0d yuv %0d %0d %0d last %b done %b",
                       out_row, out_col, luma_out, cb_out, cr_out, run_last, frame_done);
            end
          end
        end
        gap = rx_gaps ? int'($urandom_range(0, 5)) : 0;
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
        rx_wait   <= gap;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        rx_wait   <= gap - 1;
      end else begin
        out_ready <= 1'b1;
        rx_wait   <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, words_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up between back-to-back words; it only drops before a gap
  task automatic send_pixel(input smp_t y, input smp_t u, input smp_t v);
    int gap;
    gap = tx_gaps ? int'($urandom_range(0, 5)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    luma_in  <= y;
    cb_in    <= u;
    cr_in    <= v;
    do @(posedge clk); while (!in_ready);
    filter_step(y, u, v);
    pixels_sent++;
  endtask

  function automatic smp_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return smp_t'($urandom_range(0, 255));
    endcase
  endfunction

  // runs from the current position up to the end of the frame
  task automatic send_frame();
    do send_pixel(rand_sample(), rand_sample(), rand_sample());
    while (!at_frame_start());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   cfg_mode   = value[0];
      REG_WIDTH:  cfg_width  = value[WID_W-1:0];
      REG_HEIGHT: cfg_height = value[HGT_W-1:0];
      default:    ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [PDATA_W-1:0] mode, input logic [PDATA_W-1:0] width,
                              input logic [PDATA_W-1:0] height);
    write_reg(REG_MODE, mode);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
  endtask

  // smallest frames with extreme samples, both kernels, geometry below range
  task automatic test_small_frames();
    int   i;
    smp_t y;
    tx_gaps  = 1'b0;
    rx_gaps <= 1'b0;
    set_geometry(32'd0, 32'd3, 32'd3);
    for (i = 0; i < 9; i++) begin
      y = (i % 2) ? 8'hFF : 8'h00;
      send_pixel(y, ~y, smp_t'(i * 32 + 7));
    end
    drain();
    tx_gaps  = 1'b1;
    rx_gaps <= 1'b1;
    write_reg(REG_MODE, 32'd1);
    for (i = 0; i < 9; i++) send_pixel(8'hFF, 8'h00, smp_t'($urandom_range(0, 255)));
    drain();
    // width with only upper junk bits and height 1 both clamp to 3
    set_geometry(32'hFFFF_FFFF, 32'hFFFF_F000, 32'd1);
    send_frame();
    drain();
  endtask

  // the narrower frame only reads columns that the wider rows already filled
  task automatic test_resize_mid_frame();
    int i;
    set_geometry(32'd1, 32'd8, 32'd6);
    for (i = 0; i < 14; i++) send_pixel(rand_sample(), rand_sample(), rand_sample());
    drain();
    write_reg(REG_WIDTH, 32'd4);
    for (i = 0; i < 10; i++) send_pixel(rand_sample(), rand_sample(), rand_sample());
    drain();
    write_reg(REG_HEIGHT, 32'd4);
    send_frame();
    drain();
  endtask

  task automatic test_output_stall();
    set_geometry(32'd0, 32'd10, 32'd6);
    tx_gaps = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (STALL_LEN) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_frame();
    drain();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_frames();
    int start, w, h;
    start = pixels_sent;
    while (pixels_sent - start < RAND_PIXELS) begin
      w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) : int'($urandom_range(3, 12));
      h = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) : int'($urandom_range(3, 8));
      tx_gaps  = ($urandom_range(0, 3) != 0);
      rx_gaps <= ($urandom_range(0, 3) != 0);
      set_geometry(PDATA_W'($urandom_range(0, 1)), PDATA_W'(w), PDATA_W'(h));
      send_frame();
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_frames();
    test_resize_mid_frame();
    test_output_stall();
    test_random_frames();
    $display("checked %0d output words from %0d input pixels, %0d failures",
             words_seen, pixels_sent, err_count);
    $display("both kernels, small and clamped frames, resize mid-frame, long output stall");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
